// ----- hdl/grid_cross_detector_sum_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the grid crossing detector
// Concurrent assertion helpers that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef GRID_CROSS_DETECTOR_SUM_DEFINES_SVH
`define GRID_CROSS_DETECTOR_SUM_DEFINES_SVH

`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define GCDS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("grid_cross_detector_sum: invariant violated");
// Consequent must hold in the same cycle as the antecedent.
`define GCDS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid_cross_detector_sum: implication violated");
// Consequent must hold in the cycle after the antecedent.
`define GCDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid_cross_detector_sum: next-cycle check violated");
`else
`define GCDS_ASSERT_ALWAYS(label, clk, rst, cond)
`define GCDS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GCDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/gcds_pkg.sv -----
// ---------------------------------------------------------------------------
// Grid crossing detector package
// Character codes, field widths and default sizes for the detector.
// ---------------------------------------------------------------------------
package gcds_pkg;

   localparam int CHAR_W  = 8;
   localparam int SUM_W   = 32;
   localparam int COUNT_W = 15;

   localparam logic [CHAR_W-1:0] CH_SCAFFOLD = 8'd35;
   localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;

   localparam logic [SUM_W-1:0]   SUM_TOP   = '1;
   localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

   localparam int DEFAULT_MAX_WIDTH  = 128;
   localparam int DEFAULT_MAX_HEIGHT = 128;

   // Beat widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = ((CHAR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((SUM_W + COUNT_W + 7) / 8) * 8;

endpackage

// ----- hdl/grid_cross_detector_sum.sv -----
// ---------------------------------------------------------------------------
// Grid crossing detector with alignment sum
// Finds plus-shaped scaffold crossings in an ASCII raster and sums x*y.
// ---------------------------------------------------------------------------
// Throughput: one character beat per cycle, but a final character beat waits
// while an earlier result beat is still held by the receiver. The result beat
// is registered and becomes valid in the cycle after the final character beat.
// Beats pass through combinational logic between the state registers and the
// result register; the line buffer is a two-read, one-write bit memory. Reset
// clears the control state at once; no clearing pass is needed, since the row lengths guard every line buffer read.
// ---------------------------------------------------------------------------

`include "grid_cross_detector_sum_defines.svh"

module grid_cross_detector_sum #(
   parameter int MAX_WIDTH  = gcds_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = gcds_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Character stream.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gcds_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] char_code
   input  logic                            req_tlast,   // last_char
   // Result stream.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gcds_pkg::RSP_DATA_W-1:0] rsp_tdata    // [31:0] alignment_sum,
                                                        // [46:32] crossing_count
);

   // Column and row counters must be able to hold the limit itself.
   localparam int COL_W     = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
   localparam int COL_AW    = $clog2(MAX_WIDTH);
   localparam int MEM_DEPTH = 2 * (1 << COL_AW);
   localparam int PROD_W    = COL_W + ROW_W;
   localparam int SUM_W     = gcds_pkg::SUM_W;
   localparam int COUNT_W   = gcds_pkg::COUNT_W;

   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_WIDTH);
   localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(MAX_HEIGHT);

   // -------------------------------------------------------------------------
   // Image state. The line buffer holds two rows in two banks; up_bank_ff
   // says which bank is the upper row, which is overwritten by the current
   // row. The other bank is the middle row. A newline swaps the roles by
   // flipping the bank select instead of copying bits.
   // -------------------------------------------------------------------------
   logic               up_bank_ff,  up_bank_in;
   logic [COL_W-1:0]   up_len_ff,   up_len_in;
   logic [COL_W-1:0]   mid_len_ff,  mid_len_in;
   logic [COL_W-1:0]   col_ff,      col_in;
   logic [ROW_W-1:0]   row_ff,      row_in;
   logic [SUM_W-1:0]   sum_ff,      sum_in;
   logic [COUNT_W-1:0] count_ff,    count_in;

   // Sliding window over the middle row: middle[x-1] and middle[x]. The
   // memory delivers middle[x+1] and upper[x] for the current column x.
   logic               m_prev_ff,   m_prev_in;
   logic               m_cur_ff,    m_cur_in;
   logic               rd_mid_ff;
   logic               rd_up_ff;

   // Column zero of each bank kept in flops, so the window can restart at
   // the left edge right after a newline without a second lookahead read.
   logic [1:0]         first_bit_ff;

   logic               row_mem [MEM_DEPTH];

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]   rsp_sum_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   // -------------------------------------------------------------------------
   // Beat decode.
   // -------------------------------------------------------------------------
   logic [gcds_pkg::CHAR_W-1:0] char_code;
   logic                        req_fire;
   logic                        active;
   logic                        is_newline;
   logic                        is_hash;
   logic                        take_cell;
   logic                        crossing;
   logic [COL_W:0]              col_plus1;
   logic [PROD_W-1:0]           product;
   logic [SUM_W:0]              sum_wide;
   logic [SUM_W-1:0]            sum_sat;
   logic [COUNT_W-1:0]          count_sat;
   logic                        mem_wr;
   logic [COL_AW:0]             wr_addr;
   logic [COL_AW:0]             mid_addr;
   logic [COL_AW:0]             up_addr;
   logic [COL_W-1:0]            mid_col;

   assign char_code = req_tdata[gcds_pkg::CHAR_W-1:0];

   // A waiting result only blocks the next final character; every other
   // character keeps flowing because it cannot produce a result.
   assign req_tready = !rsp_valid_ff || rsp_tready || !req_tlast;
   assign req_fire   = req_tvalid && req_tready;

   // Once the height limit is reached, characters are dropped until the end.
   assign active     = (row_ff < ROW_LIMIT);
   assign is_newline = (char_code == gcds_pkg::CH_NEWLINE);
   assign is_hash    = (char_code == gcds_pkg::CH_SCAFFOLD);
   assign take_cell  = req_fire && active && !is_newline && (col_ff < COL_LIMIT);

   assign col_plus1 = {1'b0, col_ff} + 1'b1;

   // The centre sits at (x, row-1); the character just arriving is below it.
   assign crossing = is_hash && (row_ff != '0) && (col_ff != '0) &&
                     (col_plus1 < {1'b0, mid_len_ff}) && (col_ff < up_len_ff) &&
                     m_prev_ff && m_cur_ff && rd_mid_ff && rd_up_ff;

   assign product  = PROD_W'(col_ff) * PROD_W'(row_ff - 1'b1);
   assign sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(product);
   assign sum_sat  = sum_wide[SUM_W] ? gcds_pkg::SUM_TOP : sum_wide[SUM_W-1:0];
   assign count_sat = (count_ff == gcds_pkg::COUNT_TOP) ? count_ff : count_ff + 1'b1;

   // -------------------------------------------------------------------------
   // Next state.
   // -------------------------------------------------------------------------
   always_comb begin
      up_bank_in = up_bank_ff;
      up_len_in  = up_len_ff;
      mid_len_in = mid_len_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      sum_in     = sum_ff;
      count_in   = count_ff;
      m_prev_in  = m_prev_ff;
      m_cur_in   = m_cur_ff;

      if (req_fire && active && is_newline) begin
         // The finished row becomes the middle row.
         up_bank_in = !up_bank_ff;
         up_len_in  = mid_len_ff;
         mid_len_in = col_ff;
         col_in     = '0;
         row_in     = row_ff + 1'b1;
         m_cur_in   = first_bit_ff[up_bank_ff];
      end else if (take_cell) begin
         col_in    = col_plus1[COL_W-1:0];
         m_prev_in = m_cur_ff;
         m_cur_in  = rd_mid_ff;
         if (crossing) begin
            sum_in   = sum_sat;
            count_in = count_sat;
         end
      end

      // The final character is processed first, then everything restarts.
      if (req_fire && req_tlast) begin
         up_bank_in = 1'b0;
         up_len_in  = '0;
         mid_len_in = '0;
         col_in     = '0;
         row_in     = '0;
         sum_in     = '0;
         count_in   = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Memory addresses. Reads look ahead to the next state, so the registered
   // read data lines up with the column that col_ff then holds.
   assign mem_wr   = take_cell;
   assign wr_addr  = {up_bank_ff, col_ff[COL_AW-1:0]};
   assign mid_col  = col_in + 1'b1;
   assign mid_addr = {!up_bank_in, mid_col[COL_AW-1:0]};
   assign up_addr  = {up_bank_in, col_in[COL_AW-1:0]};

   // -------------------------------------------------------------------------
   // Registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         up_bank_ff   <= 1'b0;
         up_len_ff    <= '0;
         mid_len_ff   <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         up_bank_ff   <= up_bank_in;
         up_len_ff    <= up_len_in;
         mid_len_ff   <= mid_len_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_prev_ff <= m_prev_in;
      m_cur_ff  <= m_cur_in;
      if (take_cell && (col_ff == '0)) begin
         first_bit_ff[up_bank_ff] <= is_hash;
      end
      if (req_fire && req_tlast) begin
         rsp_sum_ff   <= (take_cell && crossing) ? sum_sat   : sum_ff;
         rsp_count_ff <= (take_cell && crossing) ? count_sat : count_ff;
      end
   end

   // Line buffer: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         row_mem[wr_addr] <= is_hash;
      end
      rd_mid_ff <= row_mem[mid_addr];
      rd_up_ff  <= row_mem[up_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = gcds_pkg::RSP_DATA_W'({rsp_count_ff, rsp_sum_ff});

   // -------------------------------------------------------------------------
   // Assertions.
   // -------------------------------------------------------------------------
   `GCDS_ASSERT_ALWAYS(a_col_bound, clock, reset, (col_ff <= COL_LIMIT) && (row_ff <= ROW_LIMIT))
   `GCDS_ASSERT_NEXT(a_clear_after_last, clock, reset, req_fire && req_tlast, (row_ff == '0) && (col_ff == '0) && (sum_ff == '0) && (count_ff == '0) && rsp_valid_ff)
   `GCDS_ASSERT_NEXT(a_newline_swap, clock, reset, req_fire && active && is_newline && !req_tlast, (col_ff == '0) && (up_bank_ff != $past(up_bank_ff)) && (mid_len_ff == $past(col_ff)))
   `GCDS_ASSERT_IMPLY(a_count_needs_row, clock, reset, count_ff != '0, (row_ff != '0) && (up_len_ff <= mid_len_ff || up_len_ff <= COL_LIMIT))

endmodule

// ----- tb/sv/grid_cross_detector_sum_tb.sv -----
// ---------------------------------------------------------------------------
// Testbench for the grid crossing detector
// Streams ASCII rasters into the detector, predicts the alignment sum and the
// crossing count of each image, and checks every result beat against them.
// ---------------------------------------------------------------------------
module grid_cross_detector_sum_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAR_W     = gcds_pkg::CHAR_W;
   localparam int SUM_W      = gcds_pkg::SUM_W;
   localparam int COUNT_W    = gcds_pkg::COUNT_W;
   localparam int REQ_DATA_W = gcds_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = gcds_pkg::RSP_DATA_W;

   localparam logic [CHAR_W-1:0]  CH_SCAFFOLD = gcds_pkg::CH_SCAFFOLD;
   localparam logic [CHAR_W-1:0]  CH_NEWLINE  = gcds_pkg::CH_NEWLINE;
   localparam logic [SUM_W-1:0]   SUM_TOP     = gcds_pkg::SUM_TOP;
   localparam logic [COUNT_W-1:0] COUNT_TOP   = gcds_pkg::COUNT_TOP;

   localparam int MAX_W          = gcds_pkg::DEFAULT_MAX_WIDTH;
   localparam int MAX_H          = gcds_pkg::DEFAULT_MAX_HEIGHT;
   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 7;
   localparam int ITEM_TARGET    = 1300;
   // The result beat is registered behind the final character, so a short
   // tail is plenty to catch a stray result beat after the last one.
   localparam int DRAIN_CYCLES   = 8;
   // The longest legal quiet stretch is a long sender gap stacked on a long
   // receiver stall.
   localparam int WATCHDOG_LIMIT = 5000;

   typedef enum int {IMG_NORMAL, IMG_NOISE, IMG_WIDE, IMG_TALL} image_kind_type;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } char_beat_type;

   typedef struct packed {
      logic [SUM_W-1:0]   alignment_sum;
      logic [COUNT_W-1:0] crossing_count;
   } crossing_totals_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] char_code
   logic                  req_tlast  = 1'b0; // last_char
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [31:0] alignment_sum,
                                             // [46:32] crossing_count

   grid_cross_detector_sum u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Crossing predictor. Two line buffers hold the scaffold bits of the two
   // rows above the current one. The plus centered one row up is decided when
   // the character directly below its center arrives; the older buffer is
   // overwritten in place by the current row, and the buffers trade places at
   // each newline.
   // ------------------------------------------------------------------------
   bit               prior_bits [MAX_W];
   bit               center_bits[MAX_W];
   logic [7:0]       prior_len;
   logic [7:0]       center_len;
   logic [7:0]       col_pos;
   logic [7:0]       row_pos;
   logic [SUM_W-1:0] sum_acc;
   logic [COUNT_W-1:0] count_acc;

   crossing_totals_type expected_totals[$];

   function automatic void clear_grid_state();
      for (int i = 0; i < MAX_W; i++) begin
         prior_bits[i]  = 1'b0;
         center_bits[i] = 1'b0;
      end
      prior_len  = '0;
      center_len = '0;
      col_pos    = '0;
      row_pos    = '0;
      sum_acc    = '0;
      count_acc  = '0;
   endfunction

   function automatic void absorb_char(input logic [CHAR_W-1:0] code, input logic is_last);
      int     x;
      int     y;
      bit     hash;
      bit     held;
      longint widened;
      // Once the raster is too tall, everything but the final flag is dropped.
      if (int'(row_pos) < MAX_H) begin
         if (code == CH_NEWLINE) begin
            for (int i = 0; i < MAX_W; i++) begin
               held           = prior_bits[i];
               prior_bits[i]  = center_bits[i];
               center_bits[i] = held;
            end
            prior_len  = center_len;
            center_len = col_pos;
            col_pos    = '0;
            row_pos    = row_pos + 8'd1;
         end else if (int'(col_pos) < MAX_W) begin
            // Characters past the right edge are dropped without a test.
            x    = int'(col_pos);
            hash = (code == CH_SCAFFOLD);
            if (hash && row_pos >= 8'd1 && x >= 1 && x + 1 < int'(center_len) &&
                x < int'(prior_len) && center_bits[x-1] && center_bits[x] &&
                center_bits[x+1] && prior_bits[x]) begin
               y       = int'(row_pos) - 1;
               widened = longint'(sum_acc) + longint'(x) * longint'(y);
               sum_acc = (widened > longint'(SUM_TOP)) ? SUM_TOP : SUM_W'(widened);
               if (count_acc != COUNT_TOP)
                  count_acc = count_acc + 1'b1;
            end
            prior_bits[x] = hash;
            col_pos       = 8'(x + 1);
         end
      end
      if (is_last) begin
         expected_totals.push_back('{alignment_sum: sum_acc, crossing_count: count_acc});
         clear_grid_state();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus. Images are assembled one character at a time and then moved to
   // the pending-beat queue with the final flag on their last character.
   // ------------------------------------------------------------------------
   char_beat_type     char_beats[$];
   logic [CHAR_W-1:0] image_chars[$];
   int                random_images = 0;

   // A present cell: scaffold with the given odds, else any code that is
   // neither scaffold nor newline.
   function automatic logic [CHAR_W-1:0] cell_char(input int scaffold_pct);
      logic [CHAR_W-1:0] c;
      if (int'($urandom_range(0, 99)) < scaffold_pct)
         return CH_SCAFFOLD;
      do
         c = CHAR_W'($urandom_range(0, 255));
      while (c == CH_NEWLINE || c == CH_SCAFFOLD);
      return c;
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         image_chars.push_back(s[i]);
   endtask

   // Rows of roughly equal length; jitter makes neighbors differ so that the
   // row-length guards on the line buffers get exercised.
   task automatic add_grid(input int cols, input int rows, input int pct,
                           input int jitter, input bit trailing_newline);
      int len;
      int wobble;
      for (int r = 0; r < rows; r++) begin
         wobble = $urandom_range(0, 2 * jitter);
         len    = cols + wobble - jitter;
         if (len < 0)
            len = 0;
         for (int c = 0; c < len; c++)
            image_chars.push_back(cell_char(pct));
         if (r < rows - 1 || trailing_newline)
            image_chars.push_back(CH_NEWLINE);
      end
   endtask

   task automatic flush_image();
      if (image_chars.size() == 0)
         image_chars.push_back(cell_char(50));
      foreach (image_chars[i])
         char_beats.push_back('{code: image_chars[i], last: (i == image_chars.size() - 1)});
      image_chars.delete();
   endtask

   task automatic build_directed_images();
      // A single plus whose bottom arm is the final character; the row buffer
      // also sees the lowest and highest codes as plain cells.
      image_chars = {8'h00, CH_SCAFFOLD, 8'hFF, CH_NEWLINE};
      add_text("###\n.#");
      flush_image();
      // The final character is a newline that closes its row.
      add_text("#\n");
      flush_image();
      // An image made of one lone newline.
      add_text("\n");
      flush_image();
      // The middle row is too short for the right arm, so no crossing.
      add_text("###\n##\n###");
      flush_image();
   endtask

   // The wide and tall images are large, so beyond the two forced ones they
   // are only drawn while at least half of the item budget is still open.
   task automatic build_random_images();
      image_kind_type kind;
      int             pick;
      int             n;
      while (char_beats.size() < ITEM_TARGET) begin
         pick = $urandom_range(0, 39);
         if (random_images == 0)
            kind = IMG_WIDE;
         else if (random_images == 3)
            kind = IMG_TALL;
         else if (pick == 0 && char_beats.size() < ITEM_TARGET / 2)
            kind = IMG_WIDE;
         else if (pick == 1 && char_beats.size() < ITEM_TARGET / 2)
            kind = IMG_TALL;
         else if (pick < 10)
            kind = IMG_NOISE;
         else
            kind = IMG_NORMAL;
         case (kind)
            IMG_NORMAL: begin
               add_grid($urandom_range(3, 10), $urandom_range(3, 8),
                        $urandom_range(65, 95),
                        ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2),
                        $urandom_range(0, 1));
            end
            IMG_NOISE: begin
               // Short broken images: any code at all, newlines now and then.
               n = $urandom_range(1, 8);
               for (int i = 0; i < n; i++)
                  image_chars.push_back(($urandom_range(0, 4) == 0) ?
                                        CH_NEWLINE : CHAR_W'($urandom_range(0, 255)));
            end
            IMG_WIDE: begin
               // Rows straddle the right edge of the line buffers.
               add_grid(MAX_W, $urandom_range(3, 5), 92, 4, $urandom_range(0, 1));
            end
            IMG_TALL: begin
               // Narrow rows, running past the bottom edge now and then.
               add_grid(2, $urandom_range(MAX_H - 1, MAX_H + 3), 92, 1,
                        $urandom_range(0, 1));
            end
            default: ;
         endcase
         flush_image();
         random_images++;
      end
   endtask

   // Idle lengths: mostly none or short, a few long, and every so often a
   // calm stretch with no idling at all.
   function automatic int idle_length(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r == 0) begin
         calm_left = $urandom_range(50, 200);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Character driver: moves on at the falling edge once the current beat has
   // been taken, after the gap drawn for it.
   // ------------------------------------------------------------------------
   bit req_taken = 1'b0;
   int req_gap   = 0;
   int req_calm  = 0;

   always @(negedge clock) begin
      char_beat_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (char_beats.size() > 0) begin
            beat        = char_beats.pop_front();
            req_tdata  <= REQ_DATA_W'(beat.code);
            req_tlast  <= beat.last;
            req_tvalid <= 1'b1;
            req_gap     = idle_length(req_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Result receiver: stalls at random, independent of whether a beat waits.
   int rsp_stall = 0;
   int rsp_calm  = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall   = idle_length(rsp_calm);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: feeds each accepted character to the predictor and checks each
   // accepted result beat against the oldest expected totals. The watchdog
   // counts cycles in which neither channel moves a beat.
   // ------------------------------------------------------------------------
   int mismatches  = 0;
   int idle_cycles = 0;

   always @(posedge clock) begin
      crossing_totals_type got;
      crossing_totals_type want;
      bit                  progress;
      if (!reset) begin
         progress = 1'b0;
         if (req_tvalid && req_tready) begin
            absorb_char(req_tdata[CHAR_W-1:0], req_tlast);
            req_taken = 1'b1;
            progress  = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            progress           = 1'b1;
            got.alignment_sum  = rsp_tdata[SUM_W-1:0];
            got.crossing_count = rsp_tdata[SUM_W +: COUNT_W];
            if (expected_totals.size() == 0) begin
               $display("%0t: unexpected result beat, actual sum %0d count %0d",
                        $time, got.alignment_sum, got.crossing_count);
               mismatches++;
            end else begin
               want = expected_totals.pop_front();
               if (got.alignment_sum !== want.alignment_sum) begin
                  $display("%0t: alignment_sum expected %0d actual %0d",
                           $time, want.alignment_sum, got.alignment_sum);
                  mismatches++;
               end
               if (got.crossing_count !== want.crossing_count) begin
                  $display("%0t: crossing_count expected %0d actual %0d",
                           $time, want.crossing_count, got.crossing_count);
                  mismatches++;
               end
            end
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sequence: build all images, release reset at a falling edge, then wait
   // for the stream to drain and every expected result to arrive.
   // ------------------------------------------------------------------------
   initial begin
      clear_grid_state();
      build_directed_images();
      build_random_images();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (char_beats.size() > 0 || req_tvalid)
         @(posedge clock);
      while (expected_totals.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_totals.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
